>>> rtl/fwwbc_pkg.sv
package fwwbc_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned ADDR_W = 32;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_WBACK   = 2'd2,
        KIND_FILLREQ = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic              lower_enable;
        logic              upper_enable;
    } req_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] mem_address;
        logic [DATA_W-1:0] word;
        logic              hit;
        logic              last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB_READ,
        ST_WB_SEND,
        ST_FILL_REQ,
        ST_FIN_READ,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        RD_REQ,
        RD_WBACK,
        RD_PEND
    } rd_src_t;

    typedef enum logic [1:0] {
        OUT_HIT,
        OUT_WBACK,
        OUT_FILLREQ,
        OUT_FINISH
    } out_src_t;

    typedef struct packed {
        logic     load_req;
        logic     meta_rd;
        logic     word_rd;
        rd_src_t  rd_src;
        logic     hit_update;
        logic     miss_update;
        logic     fill_write;
        logic     finish;
        logic     wb_next;
        logic     clear_row;
        logic     out_load;
        out_src_t out_src;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
        logic victim_dirty;
        logic pend_active;
        logic fill_last;
        logic wb_last;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/fwwbc_ctrl.sv
module fwwbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_operation,
    output logic              req_stall,
    input  fwwbc_pkg::stat_t  stat,
    output fwwbc_pkg::cmd_t   cmd
);
    import fwwbc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_operation) inside
                        OP_READ, OP_WRITE:
                        begin
                            if (!stat.pend_active)
                            begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        OP_FILL:
                        begin
                            if (stat.pend_active && stat.fill_last)
                            begin
                                state_next = ST_FIN_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (stat.hit)
                begin
                    if (stat.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (stat.victim_dirty)
                begin
                    state_next = ST_WB_READ;
                end
                else
                begin
                    state_next = ST_FILL_REQ;
                end
            end
            ST_WB_READ:
            begin
                state_next = ST_WB_SEND;
            end
            ST_WB_SEND:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.wb_last ? ST_FILL_REQ : ST_WB_READ;
                end
            end
            ST_FILL_REQ:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_READ:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_row = 1'b1;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_operation) inside
                        OP_READ, OP_WRITE:
                        begin
                            if (!stat.pend_active)
                            begin
                                cmd.load_req = 1'b1;
                                cmd.meta_rd  = 1'b1;
                                cmd.word_rd  = 1'b1;
                                cmd.rd_src   = RD_REQ;
                            end
                        end
                        OP_FILL:
                        begin
                            cmd.fill_write = stat.pend_active;
                        end
                        default:
                        begin
                            cmd.fill_write = 1'b0;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (stat.hit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.hit_update = 1'b1;
                        cmd.out_load   = 1'b1;
                        cmd.out_src    = OUT_HIT;
                    end
                end
                else
                begin
                    cmd.miss_update = 1'b1;
                end
            end
            ST_WB_READ:
            begin
                cmd.word_rd = 1'b1;
                cmd.rd_src  = RD_WBACK;
            end
            ST_WB_SEND:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = OUT_WBACK;
                    cmd.wb_next  = 1'b1;
                end
            end
            ST_FILL_REQ:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = OUT_FILLREQ;
                end
            end
            ST_FIN_READ:
            begin
                cmd.meta_rd = 1'b1;
                cmd.word_rd = 1'b1;
                cmd.rd_src  = RD_PEND;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_src  = OUT_FINISH;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/fwwbc_dpath.sv
module fwwbc_dpath #(
    parameter int unsigned SETS           = 128,
    parameter int unsigned WAYS           = 4,
    parameter int unsigned WORDS_PER_LINE = 8,
    parameter int unsigned KEY_BITS       = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fwwbc_pkg::req_t  req,
    input  logic             rsp_stall,
    output logic             rsp_valid,
    output fwwbc_pkg::rsp_t  rsp,
    input  fwwbc_pkg::cmd_t  cmd,
    output fwwbc_pkg::stat_t stat
);
    import fwwbc_pkg::*;

    localparam int unsigned SET_BITS   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned WORD_BITS  = $clog2(WORDS_PER_LINE);
    localparam int unsigned OFF_BITS   = WORD_BITS + 1;
    localparam int unsigned WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned WADDR_BITS = SET_BITS + WORD_BITS;
    localparam int unsigned WDEPTH     = SETS * WORDS_PER_LINE;

    typedef logic [WAYS-1:0][KEY_BITS-1:0] key_row_t;
    typedef logic [WAYS-1:0][DATA_W-1:0]   word_row_t;

    key_row_t            key_mem   [SETS];
    logic [WAYS-1:0]     valid_mem [SETS];
    logic [WAYS-1:0]     dirty_mem [SETS];
    logic [WAY_BITS-1:0] ptr_mem   [SETS];
    word_row_t           word_mem  [WDEPTH];

    key_row_t            key_rd_reg;
    logic [WAYS-1:0]     valid_rd_reg;
    logic [WAYS-1:0]     dirty_rd_reg;
    logic [WAY_BITS-1:0] ptr_rd_reg;
    word_row_t           word_rd_reg;

    logic [1:0]          req_op_reg;
    logic [ADDR_W-1:0]   req_addr_reg;
    logic [DATA_W-1:0]   req_data_reg;
    logic                req_lo_reg;
    logic                req_hi_reg;

    logic                pend_active_reg;
    logic [1:0]          pend_op_reg;
    logic [SET_BITS-1:0] pend_set_reg;
    logic [WAY_BITS-1:0] pend_way_reg;
    logic [WORD_BITS-1:0] pend_word_reg;
    logic [DATA_W-1:0]   pend_data_reg;
    logic                pend_lo_reg;
    logic                pend_hi_reg;
    logic [KEY_BITS-1:0] vict_key_reg;

    logic [WORD_BITS-1:0] fill_cnt_reg;
    logic [WORD_BITS-1:0] wb_cnt_reg;
    logic [SET_BITS-1:0]  clr_cnt_reg;

    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic [63:0]          in_addr64;
    logic [63:0]          req_addr64;
    logic [SET_BITS-1:0]  in_set;
    logic [WORD_BITS-1:0] in_w;
    logic [SET_BITS-1:0]  req_set;
    logic [WORD_BITS-1:0] req_w;
    logic [KEY_BITS-1:0]  req_key;

    logic                hit_any;
    logic [WAY_BITS-1:0] hit_way;
    logic                out_free;

    logic                meta_we;
    logic [SET_BITS-1:0] meta_waddr;
    key_row_t            key_wdata;
    logic [WAYS-1:0]     valid_wdata;
    logic [WAYS-1:0]     dirty_wdata;
    logic [WAY_BITS-1:0] ptr_wdata;
    logic [SET_BITS-1:0] meta_raddr;

    logic [WAYS-1:0]       word_we;
    logic [WADDR_BITS-1:0] word_waddr;
    logic [DATA_W-1:0]     word_wdata;
    logic [WADDR_BITS-1:0] word_raddr;

    rsp_t                rsp_next;

    function automatic logic [DATA_W-1:0] merge_bytes(
        input logic [DATA_W-1:0] old_v,
        input logic [DATA_W-1:0] new_v,
        input logic              lo,
        input logic              hi
    );
        logic [DATA_W-1:0] v;
        v = old_v;
        if (lo)
        begin
            v[7:0] = new_v[7:0];
        end
        if (hi)
        begin
            v[15:8] = new_v[15:8];
        end
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] build_addr(
        input logic [KEY_BITS-1:0]  key,
        input logic [SET_BITS-1:0]  set_idx,
        input logic [WORD_BITS-1:0] w
    );
        logic [63:0] a;
        a = (64'(key) << (OFF_BITS + SET_BITS)) | (64'(set_idx) << OFF_BITS)
            | (64'(w) << 1);
        return a[ADDR_W-1:0];
    endfunction

    assign in_addr64  = 64'(req.address);
    assign req_addr64 = 64'(req_addr_reg);
    assign in_set     = in_addr64[OFF_BITS +: SET_BITS];
    assign in_w       = in_addr64[1 +: WORD_BITS];
    assign req_set    = req_addr64[OFF_BITS +: SET_BITS];
    assign req_w      = req_addr64[1 +: WORD_BITS];
    assign req_key    = req_addr64[OFF_BITS + SET_BITS +: KEY_BITS];

    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (valid_rd_reg[i] && (key_rd_reg[i] == req_key))
            begin
                hit_any = 1'b1;
                hit_way = WAY_BITS'(i);
            end
        end
    end

    assign stat.clear_last   = (clr_cnt_reg == SET_BITS'(SETS - 1));
    assign stat.hit          = hit_any;
    assign stat.victim_dirty = valid_rd_reg[ptr_rd_reg] && dirty_rd_reg[ptr_rd_reg];
    assign stat.pend_active  = pend_active_reg;
    assign stat.fill_last    = (fill_cnt_reg == WORD_BITS'(WORDS_PER_LINE - 1));
    assign stat.wb_last      = (wb_cnt_reg == WORD_BITS'(WORDS_PER_LINE - 1));
    assign stat.out_free     = out_free;

    always_comb
    begin
        case (cmd.rd_src)
            RD_REQ:
            begin
                meta_raddr = in_set;
                word_raddr = {in_set, in_w};
            end
            RD_WBACK:
            begin
                meta_raddr = pend_set_reg;
                word_raddr = {pend_set_reg, wb_cnt_reg};
            end
            default:
            begin
                meta_raddr = pend_set_reg;
                word_raddr = {pend_set_reg, pend_word_reg};
            end
        endcase
    end

    always_comb
    begin
        meta_we     = 1'b0;
        meta_waddr  = req_set;
        key_wdata   = key_rd_reg;
        valid_wdata = valid_rd_reg;
        dirty_wdata = dirty_rd_reg;
        ptr_wdata   = ptr_rd_reg;
        if (cmd.clear_row)
        begin
            meta_we     = 1'b1;
            meta_waddr  = clr_cnt_reg;
            key_wdata   = '0;
            valid_wdata = '0;
            dirty_wdata = '0;
            ptr_wdata   = '0;
        end
        else if (cmd.hit_update)
        begin
            meta_we              = (req_op_reg == OP_WRITE) && (req_lo_reg || req_hi_reg);
            dirty_wdata[hit_way] = 1'b1;
        end
        else if (cmd.miss_update)
        begin
            meta_we                 = 1'b1;
            key_wdata[ptr_rd_reg]   = req_key;
            valid_wdata[ptr_rd_reg] = 1'b1;
            dirty_wdata[ptr_rd_reg] = 1'b0;
            ptr_wdata = (ptr_rd_reg == WAY_BITS'(WAYS - 1)) ? '0 : ptr_rd_reg + 1'b1;
        end
        else if (cmd.finish)
        begin
            meta_we    = (pend_op_reg == OP_WRITE) && (pend_lo_reg || pend_hi_reg);
            meta_waddr = pend_set_reg;
            dirty_wdata[pend_way_reg] = 1'b1;
        end
    end

    always_comb
    begin
        word_we    = '0;
        word_waddr = {req_set, req_w};
        word_wdata = merge_bytes(word_rd_reg[hit_way], req_data_reg, req_lo_reg, req_hi_reg);
        if (cmd.hit_update)
        begin
            word_we[hit_way] = (req_op_reg == OP_WRITE) && (req_lo_reg || req_hi_reg);
        end
        else if (cmd.fill_write)
        begin
            word_we[pend_way_reg] = 1'b1;
            word_waddr = {pend_set_reg, fill_cnt_reg};
            word_wdata = req.data;
        end
        else if (cmd.finish)
        begin
            word_we[pend_way_reg] = (pend_op_reg == OP_WRITE) && (pend_lo_reg || pend_hi_reg);
            word_waddr = {pend_set_reg, pend_word_reg};
            word_wdata = merge_bytes(word_rd_reg[pend_way_reg], pend_data_reg,
                                     pend_lo_reg, pend_hi_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            key_mem[meta_waddr]   <= key_wdata;
            valid_mem[meta_waddr] <= valid_wdata;
            dirty_mem[meta_waddr] <= dirty_wdata;
            ptr_mem[meta_waddr]   <= ptr_wdata;
        end
        if (cmd.meta_rd)
        begin
            key_rd_reg   <= key_mem[meta_raddr];
            valid_rd_reg <= valid_mem[meta_raddr];
            dirty_rd_reg <= dirty_mem[meta_raddr];
            ptr_rd_reg   <= ptr_mem[meta_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            if (word_we[i])
            begin
                word_mem[word_waddr][i] <= word_wdata;
            end
        end
        if (cmd.word_rd)
        begin
            word_rd_reg <= word_mem[word_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_op_reg   <= req.operation;
            req_addr_reg <= req.address;
            req_data_reg <= req.data;
            req_lo_reg   <= req.lower_enable;
            req_hi_reg   <= req.upper_enable;
        end
        if (cmd.miss_update)
        begin
            pend_op_reg   <= req_op_reg;
            pend_set_reg  <= req_set;
            pend_way_reg  <= ptr_rd_reg;
            pend_word_reg <= req_w;
            pend_data_reg <= req_data_reg;
            pend_lo_reg   <= req_lo_reg;
            pend_hi_reg   <= req_hi_reg;
            vict_key_reg  <= key_rd_reg[ptr_rd_reg];
        end
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_active_reg <= 1'b0;
            fill_cnt_reg    <= '0;
            wb_cnt_reg      <= '0;
            clr_cnt_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_row)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.miss_update)
            begin
                pend_active_reg <= 1'b1;
                fill_cnt_reg    <= '0;
                wb_cnt_reg      <= '0;
            end
            else if (cmd.finish)
            begin
                pend_active_reg <= 1'b0;
            end
            if (cmd.fill_write)
            begin
                fill_cnt_reg <= stat.fill_last ? '0 : fill_cnt_reg + 1'b1;
            end
            if (cmd.wb_next)
            begin
                wb_cnt_reg <= stat.wb_last ? '0 : wb_cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        rsp_next = '0;
        case (cmd.out_src)
            OUT_HIT:
            begin
                rsp_next.kind = (req_op_reg == OP_READ) ? KIND_READ : KIND_DONE;
                rsp_next.word = (req_op_reg == OP_READ) ? word_rd_reg[hit_way] : '0;
                rsp_next.hit  = 1'b1;
                rsp_next.last = 1'b1;
            end
            OUT_WBACK:
            begin
                rsp_next.kind        = KIND_WBACK;
                rsp_next.mem_address = build_addr(vict_key_reg, pend_set_reg, wb_cnt_reg);
                rsp_next.word        = word_rd_reg[pend_way_reg];
            end
            OUT_FILLREQ:
            begin
                rsp_next.kind        = KIND_FILLREQ;
                rsp_next.mem_address = build_addr(req_key, req_set, '0);
                rsp_next.last        = 1'b1;
            end
            default:
            begin
                rsp_next.kind = (pend_op_reg == OP_READ) ? KIND_READ : KIND_DONE;
                rsp_next.word = (pend_op_reg == OP_READ) ? word_rd_reg[pend_way_reg] : '0;
                rsp_next.last = 1'b1;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("Result word loaded over one not yet taken.");

    a_fill_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_write |-> pend_active_reg)
        else $error("Fill word written with no miss pending.");

    a_miss_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.miss_update |-> !pend_active_reg)
        else $error("Miss started while another is pending.");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_active_reg |-> (fill_cnt_reg == '0))
        else $error("Fill count nonzero with no miss pending.");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit_update |-> hit_any)
        else $error("Hit update without a matching way.");

endmodule

>>> rtl/four_way_write_back_cache.sv
// Set-associative write-back data cache with a round-robin victim per set.
// The request channel (req_valid, req_stall, req) carries reads, writes and
// fill words; a word is taken only if req_valid is high and req_stall low.
// The response channel (rsp_valid, rsp_stall, rsp) returns read data, write
// done, writeback words and fill requests; the last word caused by a request
// has its last flag set.
// A hit reads the tag and data memories as the request is taken, is compared
// in the lookup state and loads the output register, which gives the answer;
// no new request is taken until that load.
// A miss to a dirty line emits WORDS_PER_LINE writeback words, each with one
// data memory read (WB_READ) and one send (WB_SEND), then one fill request.
// While a miss is pending, fill words are taken one per cycle and reads and
// writes wait; the last fill word then reads back and finishes the access.
// After reset the block sweeps the tag memory, one set per cycle, through all
// SETS sets with req_stall high.
// While the receiver stalls, the current response holds and the block waits.
module four_way_write_back_cache #(
    parameter int unsigned SETS           = 128,
    parameter int unsigned WAYS           = 4,
    parameter int unsigned WORDS_PER_LINE = 8,
    parameter int unsigned KEY_BITS       = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  fwwbc_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output fwwbc_pkg::rsp_t  rsp
);
    import fwwbc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fwwbc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_operation (req.operation),
        .req_stall     (req_stall),
        .stat          (stat),
        .cmd           (cmd)
    );

    fwwbc_dpath #(
        .SETS           (SETS),
        .WAYS           (WAYS),
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .KEY_BITS       (KEY_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
